// File: hw/rtl/fade_blink_sequencer_macros.svh
// Assertion helpers for the fade blink sequencer.
// Define ASSERT_OFF to compile the checks out.
`ifndef FADE_BLINK_SEQUENCER_MACROS_SVH
`define FADE_BLINK_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset.
`define FBS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("fbs assertion failed");

// Next-cycle implication, disabled while in reset.
`define FBS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("fbs assertion failed");

`else

`define FBS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define FBS_ASSERT_NXT(lbl, clk, rst_n, a, b)

`endif

`endif

// File: hw/rtl/fbs_pkg.sv
package fbs_pkg;

  // Field and datapath widths
  localparam int TIME_BITS   = 16;
  localparam int FACT_W      = 8;
  localparam int STEPC_W     = 7;
  localparam int LEVEL_W     = 15;
  localparam int POS_W       = 6;
  localparam int LAST_W      = 7;
  localparam int LEVEL_SCALE = 128;
  localparam int LEVEL_SHIFT = $clog2(LEVEL_SCALE);
  localparam int MAX_STEPS   = 64;
  localparam int PROD_W      = TIME_BITS + FACT_W;
  localparam int DVD_W       = PROD_W + LEVEL_SHIFT;
  localparam int DVS_W       = PROD_W;
  localparam int QCNT_W      = $clog2(DVD_W);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int UPC_W       = 4;

  localparam logic [LAST_W-1:0] LAST_NONE = '1;

  typedef enum logic [1:0] {
    PH_FADE_IN  = 2'd0,
    PH_ON       = 2'd1,
    PH_FADE_OUT = 2'd2,
    PH_OFF      = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_START     = 3'd1,
    KIND_PAUSE     = 3'd2,
    KIND_RESUME    = 3'd3,
    KIND_SET_PHASE = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_IN_TICKS  = 3'd0,
    CFG_ON_TICKS       = 3'd1,
    CFG_FADE_OUT_TICKS = 3'd2,
    CFG_OFF_TICKS      = 3'd3,
    CFG_START_FACTOR   = 3'd4,
    CFG_END_FACTOR     = 3'd5,
    CFG_FACTOR_DEN     = 3'd6,
    CFG_STEP_COUNT     = 3'd7
  } cfg_idx_t;

  // Microprogram addresses
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t STEP_IDLE      = 4'd0;
  localparam upc_t STEP_EXEC      = 4'd1;
  localparam upc_t STEP_FRAC      = 4'd2;
  localparam upc_t STEP_MUL_POS   = 4'd3;
  localparam upc_t STEP_DIV_POS   = 4'd4;
  localparam upc_t STEP_WAIT_POS  = 4'd5;
  localparam upc_t STEP_TAKE_POS  = 4'd6;
  localparam upc_t STEP_MUL_END   = 4'd7;
  localparam upc_t STEP_MUL_START = 4'd8;
  localparam upc_t STEP_MUL_DEN   = 4'd9;
  localparam upc_t STEP_DIV_LVL   = 4'd10;
  localparam upc_t STEP_WAIT_LVL  = 4'd11;
  localparam upc_t STEP_EMIT      = 4'd12;

  // Datapath action of one control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TAKE_ITEM,
    ACT_EXEC,
    ACT_FRAC,
    ACT_MUL_POS,
    ACT_DIV_POS,
    ACT_TAKE_POS,
    ACT_MUL_END,
    ACT_MUL_START,
    ACT_MUL_DEN,
    ACT_DIV_LVL,
    ACT_EMIT
  } act_t;

  // Jump condition of one control word
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_ITEM,
    COND_NO_DRAW,
    COND_CONT,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  fin;
  } ctl_t;

  // Status from the datapath that the sequencer branches on
  typedef struct packed {
    logic no_item;
    logic no_draw;
    logic cont;
    logic div_busy;
    logic out_full;
  } flags_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// File: hw/rtl/fbs_if.sv
// Input item channel
interface fbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     kind;
  logic [1:0]                     phase_request;
  logic [fbs_pkg::TIME_BITS-1:0]  time_in_phase;

  modport source (output valid, output kind, output phase_request,
                  output time_in_phase, input ready);
  modport sink   (input valid, input kind, input phase_request,
                  input time_in_phase, output ready);
endinterface

// Result item channel
interface fbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    phase;
  logic [fbs_pkg::LEVEL_W-1:0]   level;
  logic [fbs_pkg::POS_W-1:0]     step_index;
  logic                          new_level;

  modport source (output valid, output phase, output level,
                  output step_index, output new_level, input ready);
  modport sink   (input valid, input phase, input level,
                  input step_index, input new_level, output ready);
endinterface

// Register write channel
interface fbs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbs_pkg::CFG_IDX_W-1:0]   index;
  logic [fbs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/fade_blink_sequencer.sv
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    kind, phase_request, time_in_phase
// out_ch    out  valid / ready    phase, level, step_index, new_level
// cfg_ch    in   valid / ready    index, data (cfg_ch.ready is high out of reset)
//
// An item that makes no result goes from its exec step straight back to idle.
// A redraw in continuous mode runs one division, in stepped mode two; each
// division runs the shared divider, one quotient bit per cycle.
// rst_n is synchronous; after reset the block takes items at once.
// A result waits in the output register; a stall there holds the sequencer
// only at its final step, so the next item is taken once the result is loaded.
`include "fade_blink_sequencer_macros.svh"

module fade_blink_sequencer (
  input  logic         clk,
  input  logic         rst_n,
  fbs_in_if.sink       in_ch,
  fbs_out_if.source    out_ch,
  fbs_cfg_if.sink      cfg_ch
);

  localparam int TB = fbs_pkg::TIME_BITS;
  localparam int FW = fbs_pkg::FACT_W;
  localparam int PW = fbs_pkg::PROD_W;

  fbs_pkg::ctl_t     ctl;
  fbs_pkg::flags_t   flags;
  fbs_pkg::div_req_t div_req;
  logic              div_busy;
  logic [fbs_pkg::DVD_W-1:0] quot;

  // Configuration registers
  logic [TB-1:0] fi_r, fi_nxt, on_r, on_nxt, fo_r, fo_nxt, off_r, off_nxt;
  logic [FW-1:0] sf_r, sf_nxt, ef_r, ef_nxt, fd_r, fd_nxt;
  logic [fbs_pkg::STEPC_W-1:0] sc_r, sc_nxt;

  // Sequencer state
  fbs_pkg::phase_t             phase_r, phase_nxt;
  logic [TB-1:0]               elapsed_r, elapsed_nxt;
  logic                        running_r, running_nxt;
  logic                        held_r, held_nxt;
  logic [fbs_pkg::LAST_W-1:0]  last_r, last_nxt;

  // Captured item
  logic [2:0]    kind_r, kind_nxt;
  logic [1:0]    preq_r, preq_nxt;
  logic [TB-1:0] tip_r, tip_nxt;

  // Datapath registers
  logic [TB-1:0]               num_r, num_nxt, den_r, den_nxt;
  logic [fbs_pkg::POS_W-1:0]   nm1_r, nm1_nxt, sidx_r, sidx_nxt;
  logic                        newlvl_r, newlvl_nxt;
  logic [PW-1:0]               acc_r, acc_nxt, dsr_r, dsr_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  fbs_pkg::phase_t             out_phase_r, out_phase_nxt;
  logic [fbs_pkg::LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [fbs_pkg::POS_W-1:0]   out_sidx_r, out_sidx_nxt;
  logic                        out_new_r, out_new_nxt;

  // Combinational helpers
  logic [3:0]                  nz;
  logic [TB-1:0]               len_cur, el_inc, fade_min;
  logic                        take_item, emit_go, draw;
  logic [fbs_pkg::STEPC_W-1:0] n_steps;
  logic [FW-1:0]               fd_eff;
  logic [TB-1:0]               mul_a;
  logic [FW-1:0]               mul_b;
  logic [PW-1:0]               prod;
  logic [fbs_pkg::POS_W-1:0]   pos;
  logic [fbs_pkg::LEVEL_W-1:0] level_sat;

  // First phase at or after p whose duration is not zero; p if none
  function automatic fbs_pkg::phase_t fix_ph(input logic [1:0] p, input logic [3:0] nzm);
    fbs_pkg::phase_t res;
    logic [1:0]      q;
    res = fbs_pkg::phase_t'(p);
    for (int i = 3; i >= 0; i--) begin
      q = 2'(p + 2'(i));
      if (nzm[q]) res = fbs_pkg::phase_t'(q);
    end
    return res;
  endfunction

  fbs_ucode u_ucode (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  fbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (quot)
  );

  // Handshakes and branch flags
  assign in_ch.ready    = rst_n && (ctl.act == fbs_pkg::ACT_TAKE_ITEM);
  assign cfg_ch.ready   = rst_n;
  assign take_item      = in_ch.ready && in_ch.valid;
  assign flags.no_item  = !in_ch.valid;
  assign flags.no_draw  = !draw;
  assign flags.cont     = (sc_r == '0);
  assign flags.div_busy = div_busy;
  assign flags.out_full = out_valid_r && !out_ch.ready;
  assign emit_go        = (ctl.act == fbs_pkg::ACT_EMIT) && !flags.out_full;

  // Phase durations and saturating tick
  always_comb begin
    nz = {off_r != '0, fo_r != '0, on_r != '0, fi_r != '0};
    unique case (phase_r)
      fbs_pkg::PH_FADE_IN:  len_cur = fi_r;
      fbs_pkg::PH_ON:       len_cur = on_r;
      fbs_pkg::PH_FADE_OUT: len_cur = fo_r;
      default:              len_cur = off_r;
    endcase
    el_inc   = (&elapsed_r) ? elapsed_r : TB'(elapsed_r + 1'b1);
    fade_min = (elapsed_r < len_cur) ? elapsed_r : len_cur;
  end

  // Register writes
  always_comb begin
    fi_nxt = fi_r; on_nxt = on_r; fo_nxt = fo_r; off_nxt = off_r;
    sf_nxt = sf_r; ef_nxt = ef_r; fd_nxt = fd_r; sc_nxt = sc_r;
    if (cfg_ch.valid) begin
      unique case (fbs_pkg::cfg_idx_t'(cfg_ch.index))
        fbs_pkg::CFG_FADE_IN_TICKS:  fi_nxt  = cfg_ch.data[TB-1:0];
        fbs_pkg::CFG_ON_TICKS:       on_nxt  = cfg_ch.data[TB-1:0];
        fbs_pkg::CFG_FADE_OUT_TICKS: fo_nxt  = cfg_ch.data[TB-1:0];
        fbs_pkg::CFG_OFF_TICKS:      off_nxt = cfg_ch.data[TB-1:0];
        fbs_pkg::CFG_START_FACTOR:   sf_nxt  = cfg_ch.data[FW-1:0];
        fbs_pkg::CFG_END_FACTOR:     ef_nxt  = cfg_ch.data[FW-1:0];
        fbs_pkg::CFG_FACTOR_DEN:     fd_nxt  = cfg_ch.data[FW-1:0];
        fbs_pkg::CFG_STEP_COUNT:     sc_nxt  = cfg_ch.data[fbs_pkg::STEPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item
  always_comb begin
    kind_nxt = kind_r;
    preq_nxt = preq_r;
    tip_nxt  = tip_r;
    if (take_item) begin
      kind_nxt = in_ch.kind;
      preq_nxt = in_ch.phase_request;
      tip_nxt  = in_ch.time_in_phase;
    end
  end

  // Apply the item to the phase state, update the shown step
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    running_nxt = running_r;
    held_nxt    = held_r;
    last_nxt    = last_r;
    draw        = 1'b0;
    if (ctl.act == fbs_pkg::ACT_EXEC) begin
      unique case (fbs_pkg::kind_t'(kind_r))
        fbs_pkg::KIND_TICK: begin
          elapsed_nxt = el_inc;
          if (running_r && !held_r) begin
            if (el_inc < len_cur) begin
              draw = (phase_r == fbs_pkg::PH_FADE_IN) || (phase_r == fbs_pkg::PH_FADE_OUT);
            end else begin
              phase_nxt   = fix_ph(2'(phase_r + 2'd1), nz);
              elapsed_nxt = '0;
              draw        = 1'b1;
            end
          end
        end
        fbs_pkg::KIND_START: begin
          if (!running_r) begin
            running_nxt = 1'b1;
            held_nxt    = 1'b0;
            last_nxt    = '0;
            phase_nxt   = fix_ph(phase_r, nz);
            draw        = 1'b1;
          end
        end
        fbs_pkg::KIND_PAUSE:  held_nxt = 1'b1;
        fbs_pkg::KIND_RESUME: held_nxt = 1'b0;
        fbs_pkg::KIND_SET_PHASE: begin
          phase_nxt   = fix_ph(preq_r, nz);
          elapsed_nxt = tip_r;
          draw        = running_r;
        end
        default: ;
      endcase
    end else if (ctl.act == fbs_pkg::ACT_TAKE_POS) begin
      last_nxt = {1'b0, pos};
    end
  end

  // Step count clamp, denominator guard, shared multiplier
  always_comb begin
    if (sc_r < fbs_pkg::STEPC_W'(2)) begin
      n_steps = fbs_pkg::STEPC_W'(2);
    end else if (sc_r > fbs_pkg::STEPC_W'(fbs_pkg::MAX_STEPS)) begin
      n_steps = fbs_pkg::STEPC_W'(fbs_pkg::MAX_STEPS);
    end else begin
      n_steps = sc_r;
    end
    fd_eff = (fd_r == '0) ? FW'(1) : fd_r;
    unique case (ctl.act)
      fbs_pkg::ACT_MUL_POS: begin
        mul_a = num_r;
        mul_b = FW'(nm1_r);
      end
      fbs_pkg::ACT_MUL_END: begin
        mul_a = num_r;
        mul_b = ef_r;
      end
      fbs_pkg::ACT_MUL_START: begin
        mul_a = TB'(den_r - num_r);
        mul_b = sf_r;
      end
      default: begin
        mul_a = den_r;
        mul_b = fd_eff;
      end
    endcase
    prod      = PW'(mul_a) * PW'(mul_b);
    pos       = quot[fbs_pkg::POS_W-1:0];
    level_sat = (|quot[fbs_pkg::DVD_W-1:fbs_pkg::LEVEL_W]) ? '1 : quot[fbs_pkg::LEVEL_W-1:0];
  end

  // Divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = fbs_pkg::DVD_W'(acc_r) << fbs_pkg::LEVEL_SHIFT;
    div_req.divisor  = dsr_r;
    if (ctl.act == fbs_pkg::ACT_DIV_POS) begin
      div_req.start    = 1'b1;
      div_req.dividend = fbs_pkg::DVD_W'(acc_r) + fbs_pkg::DVD_W'(den_r[TB-1:1]);
      div_req.divisor  = fbs_pkg::DVS_W'(den_r);
    end else if (ctl.act == fbs_pkg::ACT_DIV_LVL) begin
      div_req.start = 1'b1;
    end
  end

  // Fraction, products and step bookkeeping
  always_comb begin
    num_nxt    = num_r;
    den_nxt    = den_r;
    nm1_nxt    = nm1_r;
    sidx_nxt   = sidx_r;
    newlvl_nxt = newlvl_r;
    acc_nxt    = acc_r;
    dsr_nxt    = dsr_r;
    unique case (ctl.act) inside
      fbs_pkg::ACT_FRAC: begin
        nm1_nxt    = fbs_pkg::POS_W'(n_steps - 1'b1);
        sidx_nxt   = '0;
        newlvl_nxt = 1'b1;
        if (phase_r == fbs_pkg::PH_OFF) begin
          num_nxt = '0;
          den_nxt = TB'(1);
        end else if (phase_r == fbs_pkg::PH_ON) begin
          num_nxt = TB'(1);
          den_nxt = TB'(1);
        end else if (len_cur == '0) begin
          num_nxt = '0;
          den_nxt = TB'(1);
        end else begin
          num_nxt = (phase_r == fbs_pkg::PH_FADE_OUT) ? TB'(len_cur - fade_min) : fade_min;
          den_nxt = len_cur;
        end
      end
      fbs_pkg::ACT_TAKE_POS: begin
        num_nxt    = TB'(pos);
        den_nxt    = TB'(nm1_r);
        sidx_nxt   = pos;
        newlvl_nxt = ({1'b0, pos} != last_r);
      end
      fbs_pkg::ACT_MUL_POS,
      fbs_pkg::ACT_MUL_END:   acc_nxt = prod;
      fbs_pkg::ACT_MUL_START: acc_nxt = PW'(acc_r + prod);
      fbs_pkg::ACT_MUL_DEN:   dsr_nxt = prod;
      default: ;
    endcase
  end

  // Output register: load at the final step, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_phase_nxt = out_phase_r;
    out_level_nxt = out_level_r;
    out_sidx_nxt  = out_sidx_r;
    out_new_nxt   = out_new_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_phase_nxt = phase_r;
      out_level_nxt = level_sat;
      out_sidx_nxt  = sidx_r;
      out_new_nxt   = newlvl_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r        <= TB'(8);
      on_r        <= TB'(16);
      fo_r        <= TB'(8);
      off_r       <= TB'(16);
      sf_r        <= '0;
      ef_r        <= FW'(1);
      fd_r        <= FW'(1);
      sc_r        <= '0;
      phase_r     <= fbs_pkg::PH_OFF;
      elapsed_r   <= '0;
      running_r   <= 1'b0;
      held_r      <= 1'b0;
      last_r      <= fbs_pkg::LAST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      fi_r        <= fi_nxt;
      on_r        <= on_nxt;
      fo_r        <= fo_nxt;
      off_r       <= off_nxt;
      sf_r        <= sf_nxt;
      ef_r        <= ef_nxt;
      fd_r        <= fd_nxt;
      sc_r        <= sc_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      running_r   <= running_nxt;
      held_r      <= held_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    preq_r      <= preq_nxt;
    tip_r       <= tip_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    nm1_r       <= nm1_nxt;
    sidx_r      <= sidx_nxt;
    newlvl_r    <= newlvl_nxt;
    acc_r       <= acc_nxt;
    dsr_r       <= dsr_nxt;
    out_phase_r <= out_phase_nxt;
    out_level_r <= out_level_nxt;
    out_sidx_r  <= out_sidx_nxt;
    out_new_r   <= out_new_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.phase      = out_phase_r;
  assign out_ch.level      = out_level_r;
  assign out_ch.step_index = out_sidx_r;
  assign out_ch.new_level  = out_new_r;

  // The divider is only started when free and stays busy after a start
  `FBS_ASSERT_IMP(a_div_start_free, clk, rst_n, div_req.start, !div_busy)
  `FBS_ASSERT_NXT(a_div_busy_after_start, clk, rst_n, div_req.start, div_busy)
  // No item is taken while a division is in flight
  `FBS_ASSERT_IMP(a_ready_div_idle, clk, rst_n, in_ch.ready, !div_busy)
  // A stepped result never shows a step past the last one
  `FBS_ASSERT_IMP(a_step_in_range, clk, rst_n, emit_go && !flags.cont, sidx_r <= nm1_r)

endmodule

// File: hw/rtl/fbs_div.sv
// Restoring divider, one quotient bit per cycle.
module fbs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbs_pkg::div_req_t          req,
  output logic                       busy,
  output logic [fbs_pkg::DVD_W-1:0]  quot
);

  logic                              busy_r, busy_nxt;
  logic [fbs_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [fbs_pkg::DVS_W-1:0]         rem_r, rem_nxt;
  logic [fbs_pkg::DVS_W-1:0]         dvs_r, dvs_nxt;
  logic [fbs_pkg::DVD_W-1:0]         quo_r, quo_nxt;
  logic [fbs_pkg::DVS_W:0]           shifted;
  logic [fbs_pkg::DVS_W+1:0]         diff;
  logic                              fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[fbs_pkg::DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    fits    = !diff[fbs_pkg::DVS_W+1];
  end

  // Load on start, then shift one bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[fbs_pkg::DVS_W-1:0] : shifted[fbs_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[fbs_pkg::DVD_W-2:0], fits};
      cnt_nxt = fbs_pkg::QCNT_W'(cnt_r + 1'b1);
      if (cnt_r == fbs_pkg::QCNT_W'(fbs_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

// File: hw/rtl/fbs_ucode.sv
// Microprogram store and step counter.
module fbs_ucode (
  input  logic             clk,
  input  logic             rst_n,
  input  fbs_pkg::flags_t  flags,
  output fbs_pkg::ctl_t    ctl
);

  fbs_pkg::upc_t  upc_r, upc_nxt;
  logic           take_jump;

  // Control program: action, jump condition, jump target, return to idle
  function automatic fbs_pkg::ctl_t rom(input fbs_pkg::upc_t a);
    fbs_pkg::ctl_t w;
    w = '{fbs_pkg::ACT_NONE, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b1};
    unique case (a)
      fbs_pkg::STEP_IDLE:
        w = '{fbs_pkg::ACT_TAKE_ITEM, fbs_pkg::COND_NO_ITEM, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_EXEC:
        w = '{fbs_pkg::ACT_EXEC, fbs_pkg::COND_NO_DRAW, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_FRAC:
        w = '{fbs_pkg::ACT_FRAC, fbs_pkg::COND_CONT, fbs_pkg::STEP_MUL_END, 1'b0};
      fbs_pkg::STEP_MUL_POS:
        w = '{fbs_pkg::ACT_MUL_POS, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_DIV_POS:
        w = '{fbs_pkg::ACT_DIV_POS, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_WAIT_POS:
        w = '{fbs_pkg::ACT_NONE, fbs_pkg::COND_DIV_BUSY, fbs_pkg::STEP_WAIT_POS, 1'b0};
      fbs_pkg::STEP_TAKE_POS:
        w = '{fbs_pkg::ACT_TAKE_POS, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_MUL_END:
        w = '{fbs_pkg::ACT_MUL_END, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_MUL_START:
        w = '{fbs_pkg::ACT_MUL_START, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_MUL_DEN:
        w = '{fbs_pkg::ACT_MUL_DEN, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_DIV_LVL:
        w = '{fbs_pkg::ACT_DIV_LVL, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b0};
      fbs_pkg::STEP_WAIT_LVL:
        w = '{fbs_pkg::ACT_NONE, fbs_pkg::COND_DIV_BUSY, fbs_pkg::STEP_WAIT_LVL, 1'b0};
      fbs_pkg::STEP_EMIT:
        w = '{fbs_pkg::ACT_EMIT, fbs_pkg::COND_OUT_FULL, fbs_pkg::STEP_EMIT, 1'b1};
      default:
        w = '{fbs_pkg::ACT_NONE, fbs_pkg::COND_NEVER, fbs_pkg::STEP_IDLE, 1'b1};
    endcase
    return w;
  endfunction

  assign ctl = rom(upc_r);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctl.cond)
      fbs_pkg::COND_NEVER:    take_jump = 1'b0;
      fbs_pkg::COND_NO_ITEM:  take_jump = flags.no_item;
      fbs_pkg::COND_NO_DRAW:  take_jump = flags.no_draw;
      fbs_pkg::COND_CONT:     take_jump = flags.cont;
      fbs_pkg::COND_DIV_BUSY: take_jump = flags.div_busy;
      fbs_pkg::COND_OUT_FULL: take_jump = flags.out_full;
      default:                take_jump = 1'b0;
    endcase
  end

  // Jump, return to idle, or advance
  always_comb begin
    if (take_jump) begin
      upc_nxt = ctl.target;
    end else if (ctl.fin) begin
      upc_nxt = fbs_pkg::STEP_IDLE;
    end else begin
      upc_nxt = fbs_pkg::upc_t'(upc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= fbs_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ROUNDS  = 9;
  localparam int ROUND_ITEMS    = 48;

  localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
  localparam logic [2:0] KIND_LAST_SPARE  = 3'd7;

  localparam longint unsigned   LEVEL_MAX = (64'd1 << fbs_pkg::LEVEL_W) - 1;
  localparam logic [fbs_pkg::TIME_BITS-1:0] TICKS_MAX = '1;

  typedef struct packed {
    fbs_pkg::phase_t             phase;
    logic [fbs_pkg::LEVEL_W-1:0] level;
    logic [fbs_pkg::POS_W-1:0]   step_index;
    logic                        new_level;
  } brightness_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fbs_in_if  in_if  ();
  fbs_out_if out_if ();
  fbs_cfg_if cfg_if ();

  fade_blink_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the registers
  logic [fbs_pkg::TIME_BITS-1:0] phase_dur [4];
  logic [fbs_pkg::FACT_W-1:0]    start_fac;
  logic [fbs_pkg::FACT_W-1:0]    end_fac;
  logic [fbs_pkg::FACT_W-1:0]    den_fac;
  logic [fbs_pkg::STEPC_W-1:0]   step_cfg;

  // Shadow copy of the sequencer state
  fbs_pkg::phase_t               cur_phase;
  logic [fbs_pkg::TIME_BITS-1:0] elapsed;
  bit                            running;
  bit                            held;
  logic [fbs_pkg::LAST_W-1:0]    last_shown;

  brightness_t brightness_due [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          quiet       = 1'b0;

  function automatic void seq_reset();
    phase_dur[fbs_pkg::PH_FADE_IN]  = 16'd8;
    phase_dur[fbs_pkg::PH_ON]       = 16'd16;
    phase_dur[fbs_pkg::PH_FADE_OUT] = 16'd8;
    phase_dur[fbs_pkg::PH_OFF]      = 16'd16;
    start_fac  = 8'd0;
    end_fac    = 8'd1;
    den_fac    = 8'd1;
    step_cfg   = '0;
    cur_phase  = fbs_pkg::PH_OFF;
    elapsed    = '0;
    running    = 1'b0;
    held       = 1'b0;
    last_shown = fbs_pkg::LAST_NONE;
  endfunction

  function automatic void apply_reg(fbs_pkg::cfg_idx_t idx,
                                    logic [fbs_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      fbs_pkg::CFG_FADE_IN_TICKS:  phase_dur[fbs_pkg::PH_FADE_IN]  = v;
      fbs_pkg::CFG_ON_TICKS:       phase_dur[fbs_pkg::PH_ON]       = v;
      fbs_pkg::CFG_FADE_OUT_TICKS: phase_dur[fbs_pkg::PH_FADE_OUT] = v;
      fbs_pkg::CFG_OFF_TICKS:      phase_dur[fbs_pkg::PH_OFF]      = v;
      fbs_pkg::CFG_START_FACTOR:   start_fac = v[fbs_pkg::FACT_W-1:0];
      fbs_pkg::CFG_END_FACTOR:     end_fac   = v[fbs_pkg::FACT_W-1:0];
      fbs_pkg::CFG_FACTOR_DEN:     den_fac   = v[fbs_pkg::FACT_W-1:0];
      fbs_pkg::CFG_STEP_COUNT:     step_cfg  = v[fbs_pkg::STEPC_W-1:0];
      default: ;
    endcase
  endfunction

  // Walk past phases of zero length; stay put if every length is zero
  function automatic void skip_empty_phases();
    for (int i = 0; i < 4; i++) begin
      if (phase_dur[cur_phase] != '0) return;
      cur_phase = fbs_pkg::phase_t'(cur_phase + 2'd1);
    end
  endfunction

  function automatic logic [fbs_pkg::LEVEL_W-1:0] blend_level(longint unsigned num,
                                                              longint unsigned den);
    longint unsigned fd, rn, lv;
    fd = (den_fac == '0) ? 64'd1 : 64'(den_fac);
    rn = num * end_fac + (den - num) * start_fac;
    lv = (64'(fbs_pkg::LEVEL_SCALE) * rn) / (den * fd);
    if (lv > LEVEL_MAX) lv = LEVEL_MAX;
    return lv[fbs_pkg::LEVEL_W-1:0];
  endfunction

  // Build one redraw from the current phase and elapsed count
  function automatic brightness_t draw_level();
    brightness_t     r;
    longint unsigned num, den, n, pos;
    case (cur_phase)
      fbs_pkg::PH_OFF: begin
        num = 0;
        den = 1;
      end
      fbs_pkg::PH_ON: begin
        num = 1;
        den = 1;
      end
      default: begin
        den = phase_dur[cur_phase];
        num = (elapsed < den) ? 64'(elapsed) : den;
        if (cur_phase == fbs_pkg::PH_FADE_OUT) num = den - num;
        if (den == 0) begin
          num = 0;
          den = 1;
        end
      end
    endcase
    r.phase = cur_phase;
    if (step_cfg == '0) begin
      r.level      = blend_level(num, den);
      r.step_index = '0;
      r.new_level  = 1'b1;
    end else begin
      n = (step_cfg < 2) ? 64'd2 : 64'(step_cfg);
      if (n > fbs_pkg::MAX_STEPS) n = fbs_pkg::MAX_STEPS;
      pos = ((n - 1) * num + den / 2) / den;
      r.level      = blend_level(pos, n - 1);
      r.step_index = pos[fbs_pkg::POS_W-1:0];
      r.new_level  = (pos[fbs_pkg::LAST_W-1:0] != last_shown);
      last_shown   = pos[fbs_pkg::LAST_W-1:0];
    end
    return r;
  endfunction

  // Advance the shadow state by one item; return 1 when it redraws
  function automatic bit predict_brightness(logic [2:0] kind, logic [1:0] req,
                                            logic [fbs_pkg::TIME_BITS-1:0] t,
                                            output brightness_t r);
    r = '0;
    case (kind)
      fbs_pkg::KIND_TICK: begin
        if (elapsed != TICKS_MAX) elapsed++;
        if (!running || held) return 1'b0;
        if (elapsed < phase_dur[cur_phase]) begin
          if (cur_phase == fbs_pkg::PH_ON || cur_phase == fbs_pkg::PH_OFF) return 1'b0;
        end else begin
          cur_phase = fbs_pkg::phase_t'(cur_phase + 2'd1);
          skip_empty_phases();
          elapsed = '0;
        end
        r = draw_level();
        return 1'b1;
      end
      fbs_pkg::KIND_START: begin
        if (running) return 1'b0;
        running    = 1'b1;
        held       = 1'b0;
        last_shown = '0;
        skip_empty_phases();
        r = draw_level();
        return 1'b1;
      end
      fbs_pkg::KIND_PAUSE:  held = 1'b1;
      fbs_pkg::KIND_RESUME: held = 1'b0;
      fbs_pkg::KIND_SET_PHASE: begin
        cur_phase = fbs_pkg::phase_t'(req);
        skip_empty_phases();
        elapsed = t;
        if (running) begin
          r = draw_level();
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Mostly short gaps, a few long ones; none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [fbs_pkg::CFG_DATA_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return fbs_pkg::CFG_DATA_W'($urandom_range(1, 12));
    if (r < 85) return fbs_pkg::CFG_DATA_W'($urandom_range(13, 300));
    if (r < 95) return TICKS_MAX - fbs_pkg::CFG_DATA_W'($urandom_range(0, 1));
    return fbs_pkg::CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [fbs_pkg::STEPC_W-1:0] pick_steps();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 40) return fbs_pkg::STEPC_W'(1);
    if (r < 80) return fbs_pkg::STEPC_W'($urandom_range(2, fbs_pkg::MAX_STEPS));
    if (r < 90) return fbs_pkg::STEPC_W'($urandom_range(fbs_pkg::MAX_STEPS + 1, 127));
    return fbs_pkg::STEPC_W'(fbs_pkg::MAX_STEPS);
  endfunction

  // Offset into a phase, mostly near its end so the ring keeps moving
  function automatic logic [fbs_pkg::TIME_BITS-1:0] pick_offset(logic [1:0] req);
    int r, dur, t;
    dur = phase_dur[req];
    r   = $urandom_range(0, 99);
    if (r < 40) begin
      t = dur - $urandom_range(0, 3);
      if (t < 0) t = 0;
    end else if (r < 60) begin
      t = dur;
    end else if (r < 80) begin
      t = $urandom_range(0, dur);
    end else if (r < 90) begin
      t = TICKS_MAX;
    end else begin
      t = $urandom_range(0, TICKS_MAX);
    end
    return fbs_pkg::TIME_BITS'(t);
  endfunction

  // Send one item and record the redraw it should cause
  task automatic send_item(logic [2:0] kind, logic [1:0] req,
                           logic [fbs_pkg::TIME_BITS-1:0] t);
    int          gap;
    brightness_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= kind;
    in_if.phase_request <= req;
    in_if.time_in_phase <= t;
    do @(posedge clk); while (!in_if.ready);
    if (predict_brightness(kind, req, t, r)) brightness_due.push_back(r);
  endtask

  task automatic write_reg(fbs_pkg::cfg_idx_t idx, logic [fbs_pkg::CFG_DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, v);
  endtask

  task automatic program_regs(logic [fbs_pkg::CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) write_reg(fbs_pkg::cfg_idx_t'(i), vals[i]);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid, wait out every expected redraw, then let the block settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (brightness_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Commands before the first start: none of them redraws
  task automatic test_idle_commands();
    send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_PAUSE, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_RESUME, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_SET_PHASE, fbs_pkg::PH_FADE_OUT, 16'd5);
    send_item(KIND_FIRST_SPARE, fbs_pkg::PH_OFF, TICKS_MAX);
    send_item(KIND_FIRST_SPARE + 3'd1, fbs_pkg::PH_ON, 16'h5A5A);
    send_item(KIND_LAST_SPARE, fbs_pkg::PH_OFF, TICKS_MAX);
  endtask

  // Start, ignored restart, a trip round the ring, and pause around a tick
  task automatic test_start_and_ring();
    drain_results();
    program_regs('{16'd2, 16'd1, 16'd2, 16'd1, 16'd0, 16'd255, 16'd1, 16'd0});
    send_item(fbs_pkg::KIND_START, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_START, fbs_pkg::PH_FADE_IN, '0);
    repeat (6) send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_PAUSE, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_RESUME, fbs_pkg::PH_FADE_IN, '0);
    send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
  endtask

  // Zero lengths, saturated elapsed count, zero denominator, odd step counts
  task automatic test_special_cases();
    drain_results();
    program_regs('{16'd0, 16'd3, 16'd0, 16'd0, 16'd255, 16'd255, 16'd0, 16'd1});
    send_item(fbs_pkg::KIND_SET_PHASE, fbs_pkg::PH_FADE_IN, TICKS_MAX);
    send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
    drain_results();
    program_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'd17, 16'd200, 16'd3, 16'd127});
    send_item(fbs_pkg::KIND_SET_PHASE, fbs_pkg::PH_FADE_OUT, 16'd7);
    send_item(fbs_pkg::KIND_TICK, fbs_pkg::PH_FADE_IN, '0);
  endtask

  // Mostly ticks with phase jumps near the phase ends, plus pauses and noise
  task automatic run_round(int count);
    int         r;
    logic [1:0] req;
    for (int i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      req = 2'($urandom_range(0, 3));
      if (held && r < 40) begin
        send_item(fbs_pkg::KIND_RESUME, req, fbs_pkg::TIME_BITS'($urandom));
      end else if (r < 68) begin
        send_item(fbs_pkg::KIND_TICK, req, fbs_pkg::TIME_BITS'($urandom));
      end else if (r < 80) begin
        send_item(fbs_pkg::KIND_SET_PHASE, req, pick_offset(req));
      end else if (r < 86) begin
        send_item(fbs_pkg::KIND_PAUSE, req, fbs_pkg::TIME_BITS'($urandom));
      end else if (r < 90) begin
        send_item(fbs_pkg::KIND_RESUME, req, fbs_pkg::TIME_BITS'($urandom));
      end else if (r < 94) begin
        send_item(fbs_pkg::KIND_START, req, fbs_pkg::TIME_BITS'($urandom));
      end else if (r < 97) begin
        send_item(3'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE)), req,
                  fbs_pkg::TIME_BITS'($urandom));
      end else begin
        send_item(fbs_pkg::KIND_SET_PHASE, req, fbs_pkg::TIME_BITS'($urandom));
      end
    end
  endtask

  task automatic test_random_rounds();
    logic [fbs_pkg::CFG_DATA_W-1:0] vals [8];
    int                             junk;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      drain_results();
      quiet = (round % 3 == 2);
      case (round)
        0: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'd255, 16'd255, 16'd255, 16'd64};
        1: vals = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd255, 16'd0, 16'd1, 16'd2};
        default: begin
          for (int i = 0; i < 4; i++) vals[i] = pick_ticks();
          // Upper data bits beyond a register's width must be dropped
          junk = (round % 2 == 1) ? int'($urandom) : 0;
          vals[fbs_pkg::CFG_START_FACTOR] = {junk[7:0], 8'($urandom_range(0, 255))};
          vals[fbs_pkg::CFG_END_FACTOR]   = {junk[15:8], 8'($urandom_range(0, 255))};
          if ($urandom_range(0, 9) == 0)
            vals[fbs_pkg::CFG_FACTOR_DEN] = {junk[23:16], 8'd0};
          else
            vals[fbs_pkg::CFG_FACTOR_DEN] = {junk[23:16], 8'($urandom_range(1, 255))};
          vals[fbs_pkg::CFG_STEP_COUNT] = {junk[31:23], pick_steps()};
        end
      endcase
      program_regs(vals);
      run_round(ROUND_ITEMS);
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls on ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each accepted result with the oldest expected redraw
  always @(posedge clk) begin : check_results
    brightness_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (brightness_due.size() == 0) begin
        $error("unexpected result: phase %0d level %0d step_index %0d new_level %0d",
               out_if.phase, out_if.level, out_if.step_index, out_if.new_level);
        mismatches++;
      end else begin
        want = brightness_due.pop_front();
        if (out_if.phase !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, out_if.phase);
          mismatches++;
        end
        if (out_if.level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, out_if.level);
          mismatches++;
        end
        if (out_if.step_index !== want.step_index) begin
          $error("step_index: expected %0d, actual %0d", want.step_index,
                 out_if.step_index);
          mismatches++;
        end
        if (out_if.new_level !== want.new_level) begin
          $error("new_level: expected %0d, actual %0d", want.new_level,
                 out_if.new_level);
          mismatches++;
        end
      end
    end
  end

  // End the run once nothing has been accepted for too long
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.kind          = fbs_pkg::KIND_TICK;
    in_if.phase_request = '0;
    in_if.time_in_phase = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = fbs_pkg::CFG_FADE_IN_TICKS;
    cfg_if.data         = '0;
    seq_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_start_and_ring();
    test_special_cases();
    test_random_rounds();
    drain_results();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
